/* design/tod_pkg.sv */
// ---------------------------------------------------------------------------
// tod_pkg: shared types and constants for the tilt orientation detector
// Holds the request and result payloads, the register map, the
// configuration bundle and the datapath command bundle.
// ---------------------------------------------------------------------------
package tod_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_FILTER_GAIN   = 3'd0;
    localparam logic [2:0] REG_MIN_IN_PLANE  = 3'd1;
    localparam logic [2:0] REG_AXIS_WINDOW   = 3'd2;
    localparam logic [2:0] REG_HOLD_TIME     = 3'd3;
    localparam logic [2:0] REG_ORIENT_OFFSET = 3'd4;

    localparam logic [8:0]  RST_FILTER_GAIN   = 9'd51;
    localparam logic [14:0] RST_MIN_IN_PLANE  = 15'd2048;
    localparam logic [15:0] RST_AXIS_WINDOW   = 16'd37841;
    localparam logic [15:0] RST_HOLD_TIME     = 16'd300;
    localparam logic [1:0]  RST_ORIENT_OFFSET = 2'd2;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
    } t_in;

    typedef struct packed {
        logic [1:0] orientation;
        logic       changed;
    } t_out;

    typedef struct packed {
        logic [8:0]  filter_gain;
        logic [14:0] min_in_plane;
        logic [15:0] axis_window_tangent;
        logic [15:0] hold_time_ms;
        logic [1:0]  orientation_offset;
    } t_cfg;

    typedef enum logic [2:0] {
        MS_FX,
        MS_FY,
        MS_SQX,
        MS_SQY,
        MS_THR,
        MS_WIN
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     upd_fx;
        logic     upd_fy;
        logic     acc_load;
        logic     acc_add;
        logic     cmp_flat;
        logic     decide;
    } t_cmd;

endpackage

/* design/tod_regs.sv */
// ---------------------------------------------------------------------------
// tod_regs: configuration register file
// APB-style write and read access to the five control registers.
// ---------------------------------------------------------------------------
module tod_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tod_pkg::ADDR_W-1:0] paddr,
    input  logic [tod_pkg::DATA_W-1:0] pwdata,
    output logic [tod_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tod_pkg::t_cfg              o_cfg
);

    tod_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_gain         <= tod_pkg::RST_FILTER_GAIN;
            r_cfg.min_in_plane        <= tod_pkg::RST_MIN_IN_PLANE;
            r_cfg.axis_window_tangent <= tod_pkg::RST_AXIS_WINDOW;
            r_cfg.hold_time_ms        <= tod_pkg::RST_HOLD_TIME;
            r_cfg.orientation_offset  <= tod_pkg::RST_ORIENT_OFFSET;
        end else if (wr_en) begin
            unique case (reg_idx)
                tod_pkg::REG_FILTER_GAIN:   r_cfg.filter_gain <= pwdata[8:0];
                tod_pkg::REG_MIN_IN_PLANE:  r_cfg.min_in_plane <= pwdata[14:0];
                tod_pkg::REG_AXIS_WINDOW:   r_cfg.axis_window_tangent <= pwdata[15:0];
                tod_pkg::REG_HOLD_TIME:     r_cfg.hold_time_ms <= pwdata[15:0];
                tod_pkg::REG_ORIENT_OFFSET: r_cfg.orientation_offset <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tod_pkg::REG_FILTER_GAIN:   prdata = {23'd0, r_cfg.filter_gain};
            tod_pkg::REG_MIN_IN_PLANE:  prdata = {17'd0, r_cfg.min_in_plane};
            tod_pkg::REG_AXIS_WINDOW:   prdata = {16'd0, r_cfg.axis_window_tangent};
            tod_pkg::REG_HOLD_TIME:     prdata = {16'd0, r_cfg.hold_time_ms};
            tod_pkg::REG_ORIENT_OFFSET: prdata = {30'd0, r_cfg.orientation_offset};
            default:                    prdata = '0;
        endcase
    end

endmodule

/* design/tod_ctrl.sv */
// ---------------------------------------------------------------------------
// tod_ctrl: sequencer for the orientation datapath
// Walks one request through the shared multiplier steps and owns the
// request and result handshakes.
// ---------------------------------------------------------------------------
module tod_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tod_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FX,
        ST_FY,
        ST_SX,
        ST_SY,
        ST_THR,
        ST_WIN,
        ST_DEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = tod_pkg::MS_FX;
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = ST_FX;
            end
            ST_FX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tod_pkg::MS_FX;
                n_state       = ST_FY;
            end
            ST_FY: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tod_pkg::MS_FY;
                o_cmd.upd_fx  = 1'b1;
                n_state       = ST_SX;
            end
            ST_SX: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tod_pkg::MS_SQX;
                o_cmd.upd_fy  = 1'b1;
                n_state       = ST_SY;
            end
            ST_SY: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = tod_pkg::MS_SQY;
                o_cmd.acc_load = 1'b1;
                n_state        = ST_THR;
            end
            ST_THR: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = tod_pkg::MS_THR;
                o_cmd.acc_add = 1'b1;
                n_state       = ST_WIN;
            end
            ST_WIN: begin
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = tod_pkg::MS_WIN;
                o_cmd.cmp_flat = 1'b1;
                n_state        = ST_DEC;
            end
            ST_DEC: begin
                if (out_free) begin
                    o_cmd.decide = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* design/tod_dp.sv */
// ---------------------------------------------------------------------------
// tod_dp: orientation datapath
// Low-pass filter, magnitude and axis-window tests on one shared
// multiplier, then the candidate and hold-time decision.
// ---------------------------------------------------------------------------
module tod_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tod_pkg::t_cmd i_cmd,
    input  tod_pkg::t_cfg i_cfg,
    input  tod_pkg::t_in  i_in_data,
    output tod_pkg::t_out o_out_data
);

    localparam logic [1:0] ORI_UP    = 2'd0;
    localparam logic [1:0] ORI_RIGHT = 2'd1;
    localparam logic [1:0] ORI_DOWN  = 2'd2;
    localparam logic [1:0] ORI_LEFT  = 2'd3;

    logic [31:0]        r_now;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [23:0] r_fx;
    logic signed [23:0] r_fy;
    logic               r_primed;
    logic signed [49:0] r_prod;
    logic [47:0]        r_acc;
    logic               r_flat;
    logic [1:0]         r_cur;
    logic [1:0]         r_cand;
    logic [31:0]        r_start;
    tod_pkg::t_out      r_out;

    logic signed [24:0] diff_x;
    logic signed [24:0] diff_y;
    logic [23:0]        abs_x;
    logic [23:0]        abs_y;
    logic               y_major;
    logic [23:0]        major;
    logic [23:0]        minor;
    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [23:0] next_fx;
    logic signed [23:0] next_fy;
    logic               ignore;
    logic [1:0]         base;
    logic [1:0]         cand;
    logic [31:0]        elapsed;
    logic               commit;

    function automatic logic signed [23:0] filt_next(input logic signed [23:0] filt,
                                                     input logic signed [49:0] prod);
        logic signed [27:0] sum;
        sum = {{4{filt[23]}}, filt} + {prod[34], prod[34:8]};
        if (sum[27:23] == 5'b00000 || sum[27:23] == 5'b11111)
            filt_next = sum[23:0];
        else if (sum[27])
            filt_next = 24'sh800000;
        else
            filt_next = 24'sh7FFFFF;
    endfunction

    assign diff_x  = $signed({r_ax[15], r_ax, 8'd0}) - $signed({r_fx[23], r_fx});
    assign diff_y  = $signed({r_ay[15], r_ay, 8'd0}) - $signed({r_fy[23], r_fy});
    assign abs_x   = r_fx[23] ? (~r_fx + 24'd1) : r_fx;
    assign abs_y   = r_fy[23] ? (~r_fy + 24'd1) : r_fy;
    assign y_major = abs_y > abs_x;
    assign major   = y_major ? abs_y : abs_x;
    assign minor   = y_major ? abs_x : abs_y;
    assign next_fx = r_primed ? filt_next(r_fx, r_prod) : {r_ax, 8'd0};
    assign next_fy = r_primed ? filt_next(r_fy, r_prod) : {r_ay, 8'd0};
    assign ignore  = {minor, 16'd0} > r_prod[39:0];
    assign base    = y_major ? (r_fy[23] ? ORI_UP : ORI_DOWN)
                             : (r_fx[23] ? ORI_RIGHT : ORI_LEFT);
    assign cand    = base + i_cfg.orientation_offset;
    assign elapsed = r_now - r_start;
    assign commit  = !r_flat && !ignore && (cand != r_cur) && (cand == r_cand)
                     && (elapsed >= {16'd0, i_cfg.hold_time_ms});
    assign o_out_data = r_out;

    always_comb begin
        unique case (i_cmd.mul_sel)
            tod_pkg::MS_FX: begin
                mul_a = diff_x;
                mul_b = {16'd0, i_cfg.filter_gain};
            end
            tod_pkg::MS_FY: begin
                mul_a = diff_y;
                mul_b = {16'd0, i_cfg.filter_gain};
            end
            tod_pkg::MS_SQX: begin
                mul_a = {1'b0, abs_x};
                mul_b = {1'b0, abs_x};
            end
            tod_pkg::MS_SQY: begin
                mul_a = {1'b0, abs_y};
                mul_b = {1'b0, abs_y};
            end
            tod_pkg::MS_THR: begin
                mul_a = {10'd0, i_cfg.min_in_plane};
                mul_b = {10'd0, i_cfg.min_in_plane};
            end
            tod_pkg::MS_WIN: begin
                mul_a = {1'b0, major};
                mul_b = {9'd0, i_cfg.axis_window_tangent};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // payload and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now <= i_in_data.now_ms;
            r_ax  <= i_in_data.accel_x;
            r_ay  <= i_in_data.accel_y;
        end
        if (i_cmd.mul_en) r_prod <= mul_a * mul_b;
        if (i_cmd.acc_load) r_acc <= {1'b0, r_prod[46:0]};
        if (i_cmd.acc_add) r_acc <= r_acc + {1'b0, r_prod[46:0]};
        if (i_cmd.cmp_flat) r_flat <= r_acc < {2'd0, r_prod[29:0], 16'd0};
    end

    // filter and orientation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx     <= '0;
            r_fy     <= '0;
            r_primed <= 1'b0;
            r_cur    <= ORI_UP;
            r_cand   <= ORI_UP;
            r_start  <= '0;
            r_out    <= '0;
        end else begin
            if (i_cmd.upd_fx) r_fx <= next_fx;
            if (i_cmd.upd_fy) begin
                r_fy     <= next_fy;
                r_primed <= 1'b1;
            end
            if (i_cmd.decide) begin
                r_out.orientation <= commit ? cand : r_cur;
                r_out.changed     <= commit;
                if (r_flat) begin
                    r_cand <= r_cur;
                end else if (!ignore) begin
                    if (cand == r_cur) begin
                        r_cand <= cand;
                    end else if (cand != r_cand) begin
                        r_cand  <= cand;
                        r_start <= r_now;
                    end else if (commit) begin
                        r_cur <= cand;
                    end
                end
            end
        end
    end

endmodule

/* design/tilt_orientation_detector_unit.sv */
// ---------------------------------------------------------------------------
// tilt_orientation_detector_unit: accelerometer screen orientation detector
// accept to result valid: states ST_FX, ST_FY, ST_SX, ST_SY, ST_THR, ST_WIN,
//   then ST_DEC; a request is taken only in idle, as the single shared multiplier
//   does two filter products, two squares, threshold square, window product
// a finished result waits in the output register while the next request runs
// reset is synchronous, active low: registers to defaults, filter unprimed
// ---------------------------------------------------------------------------
module tilt_orientation_detector_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tod_pkg::t_in               i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tod_pkg::t_out              o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tod_pkg::ADDR_W-1:0] paddr,
    input  logic [tod_pkg::DATA_W-1:0] pwdata,
    output logic [tod_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    tod_pkg::t_cfg cfg;
    tod_pkg::t_cmd cmd;

    tod_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    tod_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

/* tb/tod_orientation_checker.sv */
// ---------------------------------------------------------------------------
// tod_orientation_checker: request/result tracking for the orientation unit
// Watches the request, result and register channels, runs its own copy of
// the low-pass filter, tilt quantizer and hold timer for every accepted
// request, and compares each accepted result in order against its forecast.
// Reports the number of failures and the number of results still owed.
// ---------------------------------------------------------------------------
module tod_orientation_checker
    import tod_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in               i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out              i_out_data,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_fail_count,
    output int                o_pending
);

    localparam logic [1:0] ORI_POS_Y = 2'd0;
    localparam logic [1:0] ORI_POS_X = 2'd1;
    localparam logic [1:0] ORI_NEG_Y = 2'd2;
    localparam logic [1:0] ORI_NEG_X = 2'd3;

    localparam longint FILT_MAX = 64'sd8388607;
    localparam longint FILT_MIN = -64'sd8388608;

    t_cfg               cfg;
    logic signed [23:0] filt_x;
    logic signed [23:0] filt_y;
    logic               primed;
    logic [1:0]         cur_ori;
    logic [1:0]         cand_ori;
    logic [31:0]        cand_start;
    t_out               owed_results[$];

    function automatic logic signed [23:0] lowpass_step(logic signed [23:0] filt,
                                                        logic signed [15:0] smp);
        longint diff;
        longint nxt;
        diff = longint'(smp) * 256 - longint'(filt);
        nxt  = longint'(filt) + ((diff * longint'(cfg.filter_gain)) >>> 8);
        if (nxt > FILT_MAX) nxt = FILT_MAX;
        if (nxt < FILT_MIN) nxt = FILT_MIN;
        return nxt[23:0];
    endfunction

    function automatic t_out track_orientation(t_in req);
        longint               gx;
        longint               gy;
        longint unsigned      absx;
        longint unsigned      absy;
        longint unsigned      mag;
        longint unsigned      thr;
        logic [1:0]           quad;
        logic [31:0]          elapsed;
        logic                 committed;
        logic                 ignored;
        t_out                 res;
        committed = 1'b0;
        ignored   = 1'b0;
        quad      = ORI_POS_Y;
        if (!primed) begin
            filt_x = {req.accel_x, 8'h00};
            filt_y = {req.accel_y, 8'h00};
            primed = 1'b1;
        end else begin
            filt_x = lowpass_step(filt_x, req.accel_x);
            filt_y = lowpass_step(filt_y, req.accel_y);
        end
        // panel axes point opposite to the sensor axes
        gx   = -longint'(filt_x);
        gy   = -longint'(filt_y);
        absx = (gx < 0) ? -gx : gx;
        absy = (gy < 0) ? -gy : gy;
        mag  = absx * absx + absy * absy;
        thr  = (longint'(cfg.min_in_plane) * longint'(cfg.min_in_plane)) << 16;
        if (mag < thr) begin
            cand_ori = cur_ori;
        end else begin
            if (absy > absx) begin
                if ((absx << 16) > absy * cfg.axis_window_tangent) ignored = 1'b1;
                else quad = (gy > 0) ? ORI_POS_Y : ORI_NEG_Y;
            end else begin
                if ((absy << 16) > absx * cfg.axis_window_tangent) ignored = 1'b1;
                else quad = (gx > 0) ? ORI_POS_X : ORI_NEG_X;
            end
            if (!ignored) begin
                quad = quad + cfg.orientation_offset;
                if (quad == cur_ori) begin
                    cand_ori = quad;
                end else if (quad != cand_ori) begin
                    cand_ori   = quad;
                    cand_start = req.now_ms;
                end else begin
                    elapsed = req.now_ms - cand_start;
                    if (elapsed >= {16'd0, cfg.hold_time_ms}) begin
                        cur_ori   = quad;
                        committed = 1'b1;
                    end
                end
            end
        end
        res.orientation = cur_ori;
        res.changed     = committed;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            cfg.filter_gain         = RST_FILTER_GAIN;
            cfg.min_in_plane        = RST_MIN_IN_PLANE;
            cfg.axis_window_tangent = RST_AXIS_WINDOW;
            cfg.hold_time_ms        = RST_HOLD_TIME;
            cfg.orientation_offset  = RST_ORIENT_OFFSET;
            filt_x       = '0;
            filt_y       = '0;
            primed       = 1'b0;
            cur_ori      = ORI_POS_Y;
            cand_ori     = ORI_POS_Y;
            cand_start   = '0;
            o_fail_count = 0;
            owed_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_FILTER_GAIN:   cfg.filter_gain         = i_pwdata[8:0];
                    REG_MIN_IN_PLANE:  cfg.min_in_plane        = i_pwdata[14:0];
                    REG_AXIS_WINDOW:   cfg.axis_window_tangent = i_pwdata[15:0];
                    REG_HOLD_TIME:     cfg.hold_time_ms        = i_pwdata[15:0];
                    REG_ORIENT_OFFSET: cfg.orientation_offset  = i_pwdata[1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: orientation %0d changed %0d",
                           i_out_data.orientation, i_out_data.changed);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    exp_res = owed_results.pop_front();
                    if (i_out_data.orientation !== exp_res.orientation) begin
                        $error("orientation: expected %0d, actual %0d",
                               exp_res.orientation, i_out_data.orientation);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_out_data.changed !== exp_res.changed) begin
                        $error("changed: expected %0d, actual %0d",
                               exp_res.changed, i_out_data.changed);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) owed_results.push_back(track_orientation(i_in_data));
        end
        o_pending = owed_results.size();
    end

endmodule

/* tb/tilt_orientation_detector_unit_test.sv */
// ---------------------------------------------------------------------------
// tilt_orientation_detector_unit_test: stimulus and verdict for the unit
// Drives directed tilt cases, then random sample streams that hold a pose
// long enough to commit, mixed with noise, across several register settings
// including the extremes. Both sides idle at random; one phase holds off the
// result side long enough to back up the request side.
// ---------------------------------------------------------------------------
module tilt_orientation_detector_unit_test;
    import tod_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in               i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out              o_out_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending;
    logic              quiet;
    logic              hold_off_req;
    logic [31:0]       clock_ms;

    tilt_orientation_detector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    tod_orientation_checker orientation_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("FAIL tilt_orientation_detector_unit");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in mk_sample(logic [31:0] t, int x, int y);
        t_in s;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        s.now_ms  = t;
        s.accel_x = x[15:0];
        s.accel_y = y[15:0];
        return s;
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int n;
        logic hold_done;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                n = gap_len();
                if (n == 0) begin
                    i_out_stall <= 1'b0;
                end else begin
                    i_out_stall <= 1'b1;
                    repeat (n - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic send_request(input t_in req, input int idle);
        repeat (idle) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] gain, input logic [31:0] min_mag,
                              input logic [31:0] tangent, input logic [31:0] hold,
                              input logic [31:0] offset);
        reg_write(REG_FILTER_GAIN, gain);
        reg_write(REG_MIN_IN_PLANE, min_mag);
        reg_write(REG_AXIS_WINDOW, tangent);
        reg_write(REG_HOLD_TIME, hold);
        reg_write(REG_ORIENT_OFFSET, offset);
    endtask

    // mostly held poses with jitter and advancing time, some raw noise
    task automatic play_traffic(input int count);
        int left;
        int len;
        int major;
        int minor;
        int px;
        int py;
        int k;
        t_in req;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 4) == 0) begin
                req.now_ms  = $urandom;
                req.accel_x = 16'($urandom);
                req.accel_y = 16'($urandom);
                send_request(req, gap_len());
                left = left - 1;
            end else begin
                if ($urandom_range(0, 9) == 0) major = $urandom_range(0, 1500);
                else major = $urandom_range(3000, 32767);
                if ($urandom_range(0, 3) == 0) minor = 0;
                else minor = $urandom_range(0, major);
                if ($urandom_range(0, 1)) minor = -minor;
                if ($urandom_range(0, 1)) major = -major;
                if ($urandom_range(0, 1)) begin
                    px = major;
                    py = minor;
                end else begin
                    px = minor;
                    py = major;
                end
                if ($urandom_range(0, 9) == 0) clock_ms = clock_ms + $urandom;
                len = $urandom_range(3, 16);
                for (k = 0; k < len && left > 0; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        clock_ms = clock_ms + $urandom_range(1000, 70000);
                    else
                        clock_ms = clock_ms + $urandom_range(1, 60);
                    req = mk_sample(clock_ms, px + $urandom_range(0, 200) - 100,
                                    py + $urandom_range(0, 200) - 100);
                    send_request(req, gap_len());
                    left = left - 1;
                end
            end
        end
    endtask

    initial begin
        int p;
        int r;
        logic [31:0] gain;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        clock_ms     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // unity gain so the filter tracks each sample exactly
        set_config(32'd256, 32'(RST_MIN_IN_PLANE), 32'(RST_AXIS_WINDOW),
                   32'(RST_HOLD_TIME), 32'(RST_ORIENT_OFFSET));
        send_request(mk_sample(32'd0, 0, 0), gap_len());
        send_request(mk_sample(32'd1, 32767, 32767), gap_len());
        send_request(mk_sample(32'd2, -32768, -32768), gap_len());
        send_request(mk_sample(32'd3, -32768, 0), gap_len());
        send_request(mk_sample(32'd100, -32768, 0), gap_len());
        send_request(mk_sample(32'd303, -32768, 0), gap_len());
        send_request(mk_sample(32'd304, 0, -32768), gap_len());
        send_request(mk_sample(32'd305, 100, 50), gap_len());
        send_request(mk_sample(32'd306, 0, -32768), gap_len());
        send_request(mk_sample(32'd605, 0, -32768), gap_len());
        send_request(mk_sample(32'd606, 0, -32768), gap_len());
        send_request(mk_sample(32'd607, 32767, 0), gap_len());
        send_request(mk_sample(32'd606, 32767, 0), gap_len());
        send_request(mk_sample(32'hFFFF_FF00, 0, 32767), gap_len());
        send_request(mk_sample(32'h0000_0100, 0, 32767), gap_len());
        send_request(mk_sample(32'h10, 32767, -32768), gap_len());
        send_request(mk_sample(32'h20, 0, 32767), gap_len());
        send_request(mk_sample(32'h30, 18477, -32000), gap_len());
        send_request(mk_sample(32'h40, 18478, -32000), gap_len());
        send_request(mk_sample(32'h50, -32768, 32767), gap_len());
        send_request(mk_sample(32'h60, 2048, 0), gap_len());
        send_request(mk_sample(32'h70, 2047, 0), gap_len());
        wait_idle();

        // register extremes
        set_config(32'd256, 32'd0, 32'd65535, 32'd0, 32'd0);
        play_traffic(80);
        wait_idle();
        set_config(32'd511, 32'd32767, 32'd0, 32'd65535, 32'd3);
        play_traffic(60);
        wait_idle();
        set_config(32'd0, 32'd1, 32'd37841, 32'd10, 32'd1);
        play_traffic(30);
        wait_idle();

        // back up the pipeline behind a long result-side hold-off
        set_config(32'(RST_FILTER_GAIN), 32'(RST_MIN_IN_PLANE), 32'(RST_AXIS_WINDOW),
                   32'(RST_HOLD_TIME), 32'(RST_ORIENT_OFFSET));
        quiet        = 1'b1;
        hold_off_req = 1'b1;
        play_traffic(30);
        quiet = 1'b0;
        wait_idle();

        for (p = 0; p < 6; p++) begin
            r = $urandom_range(0, 9);
            if (r == 0) gain = 32'd0;
            else if (r == 1) gain = $urandom_range(257, 511);
            else gain = $urandom_range(1, 256);
            set_config(gain, $urandom_range(0, 8000), $urandom_range(0, 65535),
                       $urandom_range(0, 400), $urandom_range(0, 3));
            quiet = (p == 2);
            play_traffic(90);
            quiet = 1'b0;
            wait_idle();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS tilt_orientation_detector_unit");
        end else begin
            $display("FAIL tilt_orientation_detector_unit");
        end
        $finish;
    end

endmodule

/* tilt_orientation_detector_unit.f */
design/tod_pkg.sv
design/tod_regs.sv
design/tod_ctrl.sv
design/tod_dp.sv
design/tilt_orientation_detector_unit.sv
tb/tod_orientation_checker.sv
tb/tilt_orientation_detector_unit_test.sv
